// ===== sv/terminal_padding_parser_top_defines.svh =====
// Assertion macros shared by the padding parser checker.
`ifndef TERMINAL_PADDING_PARSER_TOP_DEFINES_SVH
`define TERMINAL_PADDING_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, inactive while in reset.
`define TPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while in reset.
`define TPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TPP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tpp_pkg.sv =====
// Types, constants and helper functions of the terminal padding parser.
package tpp_pkg;

    localparam int MAX_SEQ    = 16;
    localparam int DELAY_BITS = 24;
    localparam int COUNT_W    = 24;
    localparam int LINES_W    = 12;
    localparam int LEN_W      = $clog2(MAX_SEQ + 1);
    localparam int IDX_W      = $clog2(MAX_SEQ);
    localparam int FT_W       = 11;
    localparam int NUM_W      = DELAY_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};
    localparam logic [COUNT_W-1:0]    COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] CFG_TERMCAP_MODE = 2'd0;
    localparam logic [1:0] CFG_PAD_PRESENT  = 2'd1;
    localparam logic [1:0] CFG_PAD_CHAR     = 2'd2;
    localparam logic [1:0] CFG_SPEED_CODE   = 2'd3;

    typedef enum logic [1:0] {
        OP_LIT = 2'd0,
        OP_PAD = 2'd1,
        OP_END = 2'd2
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [7:0]            ch;
        logic [DELAY_BITS-1:0] delay;
        logic                  last;
    } t_cmd;

    typedef struct packed {
        logic       termcap_mode;
        logic       pad_present;
        logic [7:0] pad_char;
        logic [4:0] speed_code;
    } t_cfg;

    function automatic logic [FT_W-1:0] frame_time(input logic [3:0] code);
        logic [FT_W-1:0] m;
        unique case (code)
            4'd0:  m = FT_W'(0);
            4'd1:  m = FT_W'(2000);
            4'd2:  m = FT_W'(1333);
            4'd3:  m = FT_W'(909);
            4'd4:  m = FT_W'(743);
            4'd5:  m = FT_W'(666);
            4'd6:  m = FT_W'(500);
            4'd7:  m = FT_W'(333);
            4'd8:  m = FT_W'(166);
            4'd9:  m = FT_W'(83);
            4'd10: m = FT_W'(55);
            4'd11: m = FT_W'(41);
            4'd12: m = FT_W'(20);
            4'd13: m = FT_W'(10);
            4'd14: m = FT_W'(5);
            default: m = FT_W'(2);
        endcase
        return m;
    endfunction

    function automatic logic [DELAY_BITS-1:0] sat_mul10_add(
        input logic [DELAY_BITS-1:0] d,
        input logic [3:0]            dig
    );
        logic [DELAY_BITS+3:0] p;
        p = ({4'b0, d} << 3) + ({4'b0, d} << 1) + (DELAY_BITS+4)'(dig);
        return (p[DELAY_BITS+3:DELAY_BITS] != 4'd0) ? DELAY_MAX : p[DELAY_BITS-1:0];
    endfunction

    function automatic logic [DELAY_BITS-1:0] sat_add(
        input logic [DELAY_BITS-1:0] d,
        input logic [3:0]            dig
    );
        logic [DELAY_BITS:0] s;
        s = {1'b0, d} + (DELAY_BITS+1)'(dig);
        return s[DELAY_BITS] ? DELAY_MAX : s[DELAY_BITS-1:0];
    endfunction

    function automatic logic [DELAY_BITS-1:0] sat_mul_lines(
        input logic [DELAY_BITS-1:0] d,
        input logic [LINES_W-1:0]    l
    );
        logic [DELAY_BITS+LINES_W-1:0] p;
        p = (DELAY_BITS+LINES_W)'(d) * (DELAY_BITS+LINES_W)'(l);
        return (p[DELAY_BITS+LINES_W-1:DELAY_BITS] != '0) ? DELAY_MAX
                                                         : p[DELAY_BITS-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [NUM_W-1:0] q);
        logic [NUM_W+COUNT_W-1:0] w;
        w = (NUM_W+COUNT_W)'(q);
        return ((w >> COUNT_W) != '0) ? COUNT_MAX : w[COUNT_W-1:0];
    endfunction

endpackage

// ===== sv/tpp_in_if.sv =====
// Input channel: one control-string byte per word.
interface tpp_in_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    in_char;
    logic                          end_of_string;
    logic [tpp_pkg::LINES_W-1:0]   affected_lines;

    modport source (output valid, output in_char, output end_of_string,
                    output affected_lines, input ready);
    modport sink   (input valid, input in_char, input end_of_string,
                    input affected_lines, output ready);
endinterface

// ===== sv/tpp_out_if.sv =====
// Output channel: one literal byte or pad run per word.
interface tpp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [7:0]                    out_char;
    logic [tpp_pkg::COUNT_W-1:0]   pad_count;
    logic                          last_of_run;

    modport source (output valid, output kind, output out_char, output pad_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input out_char, input pad_count,
                    input last_of_run, output ready);
endinterface

// ===== sv/tpp_front.sv =====
// Front end: parses control-string bytes and issues literal, pad and end commands.
module tpp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tpp_in_if.sink          i_in,
    input  tpp_pkg::t_cfg   i_cfg,
    output tpp_pkg::t_cmd   o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready
);
    import tpp_pkg::*;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [5:0] {
        F_IDLE   = 6'b000001,
        F_PARSE  = 6'b000010,
        F_MUL    = 6'b000100,
        F_REPLAY = 6'b001000,
        F_FIN    = 6'b010000,
        F_END    = 6'b100000
    } t_fstate;

    typedef enum logic [10:0] {
        PH_START  = 11'b00000000001,
        TI_IDLE   = 11'b00000000010,
        TI_DOLLAR = 11'b00000000100,
        TI_INT    = 11'b00000001000,
        TI_FRAC1  = 11'b00000010000,
        TI_FRAC2  = 11'b00000100000,
        TI_STAR   = 11'b00001000000,
        TC_INT    = 11'b00010000000,
        TC_FRAC1  = 11'b00100000000,
        TC_FRAC2  = 11'b01000000000,
        TC_BODY   = 11'b10000000000
    } t_phase;

    t_fstate               r_st, n_st;
    t_phase                r_phase, n_phase;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [DELAY_BITS-1:0] r_delay, n_delay;
    logic [7:0]            r_ch, n_ch;
    logic                  r_end, n_end;
    logic [LINES_W-1:0]    r_lines, n_lines;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_rescan, n_rescan;
    logic [7:0]            r_buf [MAX_SEQ];

    // parse-step results
    t_phase                p_ph, p_phase;
    logic [DELAY_BITS-1:0] p_d, p_delay, p_pad_d, p_d10, p_d10d, p_dadd;
    logic [LEN_W-1:0]      p_len;
    logic                  p_app, p_lit, p_pad, p_rep, p_mul, p_isdig, p_tc;
    logic [3:0]            p_dig;
    logic [LEN_W-1:0]      p_len_inc;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic                  ph_is_tc;
    logic [LEN_W-1:0]      idx_inc;

    assign i_in.ready = (r_st == F_IDLE);
    assign ph_is_tc   = (r_phase == TC_INT) || (r_phase == TC_FRAC1) ||
                        (r_phase == TC_FRAC2) || (r_phase == TC_BODY);
    assign idx_inc    = LEN_W'(r_idx) + LEN_W'(1);

    always_comb begin
        p_ph    = (r_phase == PH_START) ? (i_cfg.termcap_mode ? TC_INT : TI_IDLE) : r_phase;
        p_d     = (r_phase == PH_START) ? '0 : r_delay;
        p_len   = (r_phase == PH_START) ? '0 : r_len;
        p_isdig = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
        p_dig   = 4'(r_ch - CH_ZERO);
        p_d10   = sat_mul10_add(p_d, 4'd0);
        p_d10d  = sat_mul10_add(p_d, p_dig);
        p_dadd  = sat_add(p_d, p_dig);
        p_tc    = (p_ph == TC_INT) || (p_ph == TC_FRAC1) ||
                  (p_ph == TC_FRAC2) || (p_ph == TC_BODY);
        p_phase = p_ph;
        p_delay = p_d;
        p_pad_d = p_d;
        p_app   = 1'b0;
        p_lit   = 1'b0;
        p_pad   = 1'b0;
        p_rep   = 1'b0;
        p_mul   = 1'b0;
        if (p_ph == TI_IDLE) begin
            if (r_ch == CH_DOLLAR) begin
                p_app   = 1'b1;
                p_phase = TI_DOLLAR;
            end else begin
                p_lit = 1'b1;
            end
        end else if (p_ph == TI_DOLLAR) begin
            if (r_ch == CH_LT) begin
                p_delay = '0;
                p_app   = 1'b1;
                p_phase = TI_INT;
            end else begin
                p_rep = 1'b1;
            end
        end else if (!p_tc) begin
            if (r_ch == CH_GT) begin
                p_pad   = 1'b1;
                p_pad_d = (p_ph == TI_INT) ? p_d10 : p_d;
                p_delay = '0;
                p_phase = TI_IDLE;
            end else if (p_ph != TI_STAR && r_ch == CH_STAR) begin
                p_delay = (p_ph == TI_INT) ? p_d10 : p_d;
                p_phase = TI_STAR;
                p_app   = 1'b1;
                p_mul   = 1'b1;
            end else if (p_ph == TI_INT && p_isdig) begin
                p_delay = p_d10d;
                p_app   = 1'b1;
            end else if (p_ph == TI_INT && r_ch == CH_DOT) begin
                p_delay = p_d10;
                p_phase = TI_FRAC1;
                p_app   = 1'b1;
            end else if (p_ph == TI_FRAC1 && p_isdig) begin
                p_delay = p_dadd;
                p_phase = TI_FRAC2;
                p_app   = 1'b1;
            end else if (p_ph == TI_FRAC2 && p_isdig) begin
                p_app = 1'b1;
            end else begin
                p_rep = 1'b1;
            end
        end else begin
            if (p_ph == TC_BODY) begin
                p_lit = 1'b1;
            end else if (p_ph == TC_INT && p_isdig) begin
                p_delay = p_d10d;
            end else if (p_ph == TC_INT && r_ch == CH_DOT) begin
                p_delay = p_d10;
                p_phase = TC_FRAC1;
            end else if (p_ph == TC_FRAC1 && p_isdig) begin
                p_delay = p_dadd;
                p_phase = TC_FRAC2;
            end else if (p_ph == TC_FRAC2 && p_isdig) begin
                p_delay = p_d;
            end else begin
                p_phase = TC_BODY;
                p_delay = (p_ph == TC_INT) ? p_d10 : p_d;
                if (r_ch == CH_STAR) begin
                    p_mul = 1'b1;
                end else begin
                    p_lit = 1'b1;
                end
            end
        end
        p_len_inc = p_len + LEN_W'(1);
    end

    always_comb begin
        n_st        = r_st;
        n_phase     = r_phase;
        n_len       = r_len;
        n_delay     = r_delay;
        n_ch        = r_ch;
        n_end       = r_end;
        n_lines     = r_lines;
        n_idx       = r_idx;
        n_rescan    = r_rescan;
        wr_en       = 1'b0;
        wr_idx      = p_len[IDX_W-1:0];
        o_cmd_valid = 1'b0;
        o_cmd       = '{op: OP_END, ch: r_ch, delay: r_delay, last: 1'b1};
        unique case (r_st)
            F_IDLE: begin
                if (i_in.valid) begin
                    n_ch    = i_in.in_char;
                    n_end   = i_in.end_of_string;
                    n_lines = i_in.affected_lines;
                    n_st    = F_PARSE;
                end
            end
            F_PARSE: begin
                if (p_lit || p_pad) begin
                    o_cmd_valid = 1'b1;
                    o_cmd = '{op: p_lit ? OP_LIT : OP_PAD, ch: r_ch, delay: p_pad_d,
                              last: !r_end};
                end
                // hold the whole step until the queue takes its word
                if (!((p_lit || p_pad) && !i_cmd_ready)) begin
                    n_phase = p_phase;
                    n_delay = p_delay;
                    n_len   = p_pad ? '0 : p_len;
                    if (p_app) begin
                        wr_en = 1'b1;
                        n_len = p_len_inc;
                    end
                    if (p_rep) begin
                        n_st     = F_REPLAY;
                        n_idx    = '0;
                        n_rescan = 1'b1;
                    end else if (p_mul) begin
                        n_st = F_MUL;
                    end else if (p_app && p_len_inc == LEN_W'(MAX_SEQ)) begin
                        n_st     = F_REPLAY;
                        n_idx    = '0;
                        n_rescan = 1'b0;
                    end else begin
                        n_st = r_end ? F_FIN : F_IDLE;
                    end
                end
            end
            F_MUL: begin
                n_delay = sat_mul_lines(r_delay, r_lines);
                if (r_len == LEN_W'(MAX_SEQ)) begin
                    n_st     = F_REPLAY;
                    n_idx    = '0;
                    n_rescan = 1'b0;
                end else begin
                    n_st = r_end ? F_FIN : F_IDLE;
                end
            end
            F_REPLAY: begin
                o_cmd_valid = 1'b1;
                // the final replayed word closes the step unless more follows
                o_cmd = '{op: OP_LIT, ch: r_buf[r_idx], delay: r_delay,
                          last: (idx_inc >= r_len) && !r_rescan && !r_end};
                if (i_cmd_ready) begin
                    if (idx_inc >= r_len) begin
                        n_len   = '0;
                        n_phase = TI_IDLE;
                        n_st    = r_rescan ? F_PARSE : (r_end ? F_FIN : F_IDLE);
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            F_FIN: begin
                if (ph_is_tc) begin
                    o_cmd_valid = 1'b1;
                    o_cmd = '{op: OP_PAD, ch: r_ch,
                              delay: (r_phase == TC_INT) ? sat_mul10_add(r_delay, 4'd0)
                                                         : r_delay,
                              last: 1'b1};
                    if (i_cmd_ready) begin
                        n_phase = PH_START;
                        n_len   = '0;
                        n_delay = '0;
                        n_st    = F_IDLE;
                    end
                end else if (r_phase != TI_IDLE) begin
                    n_st     = F_REPLAY;
                    n_idx    = '0;
                    n_rescan = 1'b0;
                end else begin
                    n_phase = PH_START;
                    n_len   = '0;
                    n_delay = '0;
                    n_st    = F_END;
                end
            end
            F_END: begin
                o_cmd_valid = 1'b1;
                if (i_cmd_ready) begin
                    n_st = F_IDLE;
                end
            end
            default: n_st = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= F_IDLE;
            r_phase  <= PH_START;
            r_len    <= '0;
            r_delay  <= '0;
            r_idx    <= '0;
            r_rescan <= 1'b0;
            r_end    <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_delay  <= n_delay;
            r_idx    <= n_idx;
            r_rescan <= n_rescan;
            r_end    <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_lines <= n_lines;
        if (wr_en) begin
            r_buf[wr_idx] <= r_ch;
        end
    end

endmodule

// ===== sv/tpp_queue.sv =====
// Command queue between the front end and the back end.
module tpp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpp_pkg::t_cmd   i_cmd,
    input  logic            i_valid,
    output logic            o_ready,
    output tpp_pkg::t_cmd   o_cmd,
    output logic            o_valid,
    input  logic            i_ready
);
    import tpp_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== sv/tpp_back.sv =====
// Back end: turns commands into result words, divides delays into pad counts.
module tpp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpp_pkg::t_cmd   i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  tpp_pkg::t_cfg   i_cfg,
    tpp_out_if.source       o_out
);
    import tpp_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_DIV   = 3'b010,
        B_MERGE = 3'b100
    } t_bstate;

    typedef struct packed {
        logic               kind;
        logic [7:0]         ch;
        logic [COUNT_W-1:0] cnt;
    } t_res;

    t_bstate              r_st;
    logic                 r_e, r_has, r_pv, r_ov, r_olast;
    t_res                 r_new, r_pend, r_out;
    logic [NUM_W-1:0]     r_num, r_quo;
    logic [FT_W-1:0]      r_rem, r_m;
    logic [DIV_CNT_W-1:0] r_bit;

    logic                 pad_en, ofree, qb, ov_set;
    logic [FT_W:0]        trial;
    logic [FT_W-1:0]      m_sel;
    logic [NUM_W-1:0]     q_fin;

    assign o_cmd_ready      = (r_st == B_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.kind       = r_out.kind;
    assign o_out.out_char   = r_out.ch;
    assign o_out.pad_count  = r_out.cnt;
    assign o_out.last_of_run = r_olast;

    assign m_sel  = frame_time(i_cfg.speed_code[3:0]);
    assign pad_en = i_cfg.pad_present && (i_cmd.delay != '0) &&
                    (i_cfg.speed_code != 5'd0) && !i_cfg.speed_code[4];
    assign ofree  = !r_ov || o_out.ready;
    assign trial  = {r_rem, r_num[NUM_W-1]};
    assign qb     = (trial >= {1'b0, r_m});
    assign q_fin  = {r_quo[NUM_W-2:0], qb};
    // a word is loaded into the output register this cycle
    assign ov_set = (r_st == B_MERGE) && ofree &&
                    ((r_has && (r_pv || r_e)) || (!r_has && r_e && r_pv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= B_IDLE;
            r_has <= 1'b0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
            r_e   <= 1'b0;
        end else begin
            r_ov <= ov_set || (r_ov && !o_out.ready);
            unique case (r_st)
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        r_e <= i_cmd.last;
                        unique case (i_cmd.op)
                            OP_LIT: begin
                                r_has <= 1'b1;
                                r_st  <= B_MERGE;
                            end
                            OP_PAD: begin
                                r_has <= 1'b0;
                                r_st  <= pad_en ? B_DIV : B_MERGE;
                            end
                            default: begin
                                r_has <= 1'b0;
                                r_st  <= B_MERGE;
                            end
                        endcase
                    end
                end
                B_DIV: begin
                    if (r_bit == DIV_CNT_W'(NUM_W - 1)) begin
                        r_has <= (q_fin != '0);
                        r_st  <= B_MERGE;
                    end
                end
                B_MERGE: begin
                    if (r_has) begin
                        if (r_pv) begin
                            // release the held word, keep the new one for the step end
                            if (ofree) begin
                                r_has <= 1'b0;
                                if (!r_e) begin
                                    r_st <= B_IDLE;
                                end
                            end
                        end else if (r_e) begin
                            if (ofree) begin
                                r_has <= 1'b0;
                                r_st  <= B_IDLE;
                            end
                        end else begin
                            r_pv  <= 1'b1;
                            r_has <= 1'b0;
                            r_st  <= B_IDLE;
                        end
                    end else if (r_e && r_pv) begin
                        if (ofree) begin
                            r_pv <= 1'b0;
                            r_st <= B_IDLE;
                        end
                    end else begin
                        r_st <= B_IDLE;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            B_IDLE: begin
                r_new <= '{kind: 1'b0, ch: i_cmd.ch, cnt: COUNT_W'(1)};
                r_num <= NUM_W'(i_cmd.delay) + NUM_W'(m_sel >> 1);
                r_m   <= m_sel;
                r_rem <= '0;
                r_quo <= '0;
                r_bit <= '0;
            end
            B_DIV: begin
                r_rem <= qb ? FT_W'(trial - {1'b0, r_m}) : trial[FT_W-1:0];
                r_num <= r_num << 1;
                r_quo <= q_fin;
                r_bit <= r_bit + DIV_CNT_W'(1);
                r_new <= '{kind: 1'b1, ch: i_cfg.pad_char, cnt: sat_count(q_fin)};
            end
            B_MERGE: begin
                if (r_has && r_pv && ofree) begin
                    r_out   <= r_pend;
                    r_olast <= 1'b0;
                    r_pend  <= r_new;
                end else if (r_has && !r_pv && r_e && ofree) begin
                    r_out   <= r_new;
                    r_olast <= 1'b1;
                end else if (r_has && !r_pv && !r_e) begin
                    r_pend <= r_new;
                end else if (!r_has && r_e && r_pv && ofree) begin
                    r_out   <= r_pend;
                    r_olast <= 1'b1;
                end
            end
            default: r_bit <= '0;
        endcase
    end

endmodule

// ===== sv/terminal_padding_parser_top.sv =====
// The front end captures and parses a byte, queues a command, and the
// back end loads it into its output register; an enabled pad run passes
// the bit-serial divider too. No new byte is taken before the last is parsed;
// a replay issues one buffered byte per cycle while the queue accepts.
// Reset: synchronous, active low; clears parser, queue, back end and
// configuration registers. The sequence buffer is not cleared.
module terminal_padding_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpp_in_if.sink     i_in,
    tpp_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import tpp_pkg::*;

    t_cfg r_cfg;
    t_cmd f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TERMCAP_MODE: r_cfg.termcap_mode <= i_cfg_data[0];
                CFG_PAD_PRESENT:  r_cfg.pad_present  <= i_cfg_data[0];
                CFG_PAD_CHAR:     r_cfg.pad_char     <= i_cfg_data;
                CFG_SPEED_CODE:   r_cfg.speed_code   <= i_cfg_data[4:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    tpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_cmd       (f_cmd),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready)
    );

    tpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (f_cmd),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .o_cmd   (q_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready)
    );

    tpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cfg       (r_cfg),
        .o_out       (o_out)
    );

endmodule

// ===== sv/tpp_checker.sv =====
// Port-level checks on the padding parser output channel, bound to the top level.
`include "terminal_padding_parser_top_defines.svh"

module tpp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_kind,
    input logic [tpp_pkg::COUNT_W-1:0] i_out_pad_count
);
    import tpp_pkg::*;

    `TPP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output word dropped while stalled")
    `TPP_ASSERT_NOW(a_lit_count, i_out_valid && !i_out_kind, i_out_pad_count == COUNT_W'(1), "literal word count is not one")
    `TPP_ASSERT_NOW(a_pad_count, i_out_valid && i_out_kind, i_out_pad_count != '0, "empty pad run")
    `TPP_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n, !i_out_valid, "output valid right after reset")

endmodule

bind terminal_padding_parser_top tpp_checker u_tpp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_kind      (o_out.kind),
    .i_out_pad_count (o_out.pad_count)
);
